FILE: sv/kji_pkg.sv
// Shared types, constants and codes for the keyframe joint interpolator.
// No dependencies; kji_ctrl, kji_dp and the top import this package.
package kji_pkg;

	localparam int MAX_KF   = 32;
	localparam int NUM_JNT  = 32;
	localparam int KF_W     = $clog2(MAX_KF);
	localparam int JN_W     = $clog2(NUM_JNT);
	localparam int CNT_W    = 6;
	localparam int TIME_W   = 20;
	localparam int POS_W    = 16;
	localparam int STF_W    = 13;
	localparam int DUR_W    = TIME_W + 1;
	localparam int PROD_W   = POS_W + DUR_W;
	localparam int NUM_W    = PROD_W + 1;
	localparam int QUO_W    = POS_W + 1;
	localparam int DCNT_W   = $clog2(QUO_W);
	localparam int RAM_DEPTH = MAX_KF * NUM_JNT;
	localparam int RAM_AW   = KF_W + JN_W;

	localparam logic [STF_W-1:0] STF_MAX = STF_W'(4096);

	// input op codes
	localparam logic [2:0] OP_LOAD   = 3'd0;
	localparam logic [2:0] OP_START  = 3'd1;
	localparam logic [2:0] OP_BEGIN  = 3'd2;
	localparam logic [2:0] OP_TICK   = 3'd3;
	localparam logic [2:0] OP_CANCEL = 3'd4;

	// result status codes
	localparam logic [2:0] RS_SAMPLE   = 3'd0;
	localparam logic [2:0] RS_FINISHED = 3'd1;
	localparam logic [2:0] RS_CANCELED = 3'd2;
	localparam logic [2:0] RS_IDLE     = 3'd3;
	localparam logic [2:0] RS_MISSING  = 3'd4;

	// input word without op, last field lowest
	typedef struct packed {
		logic                    has_stiffness;
		logic                    has_position;
		logic [STF_W-1:0]        stiffness;
		logic signed [POS_W-1:0] position;
		logic [TIME_W-1:0]       elapsed_ms;
		logic [4:0]              joint_index;
		logic [4:0]              frame_index;
	} in_item_t;

	typedef struct packed {
		logic [STF_W-1:0]        joint_stiffness;
		logic signed [POS_W-1:0] joint_position;
		logic [4:0]              joint_number;
	} out_item_t;

	// one keyframe entry for one joint
	typedef struct packed {
		logic                    pos_ok;
		logic signed [POS_W-1:0] pos;
		logic                    stf_ok;
		logic [STF_W-1:0]        stf;
	} kf_entry_t;

	typedef struct packed {
		logic       clr;
		logic       accept;
		logic       mask_clr;
		logic       scan_clr;
		logic       scan_step;
		logic       first;
		logic       jnt_clr;
		logic       jnt_inc;
		logic       rd_prev;
		logic       cap_nxt;
		logic       chk_eval;
		logic       mul;
		logic       add;
		logic       pre;
		logic       div_step;
		logic       emit_smp;
		logic       emit_res;
		logic [2:0] res_code;
	} kji_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic cnt_zero;
		logic scan_last;
		logic cur_ge;
		logic jnt_last;
		logic jnt_sel;
		logic missing;
		logic div_done;
		logic out_free;
		logic last_sel;
	} kji_stat_t;

endpackage

FILE: sv/kji_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kji_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/kji_ctrl.sv
// Sequencing state machine of the keyframe joint interpolator.
// Depends on kji_pkg; drives kji_dp through command and status structs.
module kji_ctrl
	import kji_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic [2:0] op,
	output logic      in_ready,
	input  kji_stat_t st,
	output kji_cmd_t  cmd
);

	typedef enum logic [13:0] {
		S_CLR   = 14'b00000000000001,
		S_IDLE  = 14'b00000000000010,
		S_SCAN  = 14'b00000000000100,
		S_C_RDN = 14'b00000000001000,
		S_C_RDP = 14'b00000000010000,
		S_C_EVL = 14'b00000000100000,
		S_P_RDN = 14'b00000001000000,
		S_P_RDP = 14'b00000010000000,
		S_P_MUL = 14'b00000100000000,
		S_P_ADD = 14'b00001000000000,
		S_P_PRE = 14'b00010000000000,
		S_P_DIV = 14'b00100000000000,
		S_P_EMT = 14'b01000000000000,
		S_RES   = 14'b10000000000000
	} state_t;

	state_t     state_q, nxt;
	logic       active_q, act_d;
	logic       first_q, first_d;
	logic [2:0] code_q, code_d;

	always_comb begin
		nxt      = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		act_d    = active_q;
		first_d  = first_q;
		code_d   = code_q;
		case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (st.clr_done) begin
					nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (op)
						OP_BEGIN: begin
							act_d        = 1'b1;
							first_d      = 1'b1;
							cmd.mask_clr = 1'b1;
						end
						OP_CANCEL: begin
							code_d = active_q ? RS_CANCELED : RS_IDLE;
							act_d  = 1'b0;
							nxt    = S_RES;
						end
						OP_TICK: begin
							if (active_q) begin
								cmd.scan_clr = 1'b1;
								nxt          = S_SCAN;
							end else begin
								code_d = RS_IDLE;
								nxt    = S_RES;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.cnt_zero || (st.scan_last && st.cur_ge)) begin
					code_d = RS_FINISHED;
					act_d  = 1'b0;
					nxt    = S_RES;
				end else if (st.scan_last) begin
					cmd.jnt_clr = 1'b1;
					nxt         = S_C_RDN;
				end
			end
			S_C_RDN: nxt = S_C_RDP;
			S_C_RDP: begin
				cmd.rd_prev = 1'b1;
				cmd.cap_nxt = 1'b1;
				nxt         = S_C_EVL;
			end
			S_C_EVL: begin
				cmd.chk_eval = 1'b1;
				if (st.jnt_last) begin
					first_d = 1'b0;
					if (st.missing) begin
						code_d = RS_MISSING;
						nxt    = S_RES;
					end else begin
						cmd.jnt_clr = 1'b1;
						nxt         = S_P_RDN;
					end
				end else begin
					cmd.jnt_inc = 1'b1;
					nxt         = S_C_RDN;
				end
			end
			S_P_RDN: begin
				if (st.jnt_sel) begin
					nxt = S_P_RDP;
				end else if (st.jnt_last) begin
					nxt = S_IDLE;
				end else begin
					cmd.jnt_inc = 1'b1;
				end
			end
			S_P_RDP: begin
				cmd.rd_prev = 1'b1;
				cmd.cap_nxt = 1'b1;
				nxt         = S_P_MUL;
			end
			S_P_MUL: begin
				cmd.mul = 1'b1;
				nxt     = S_P_ADD;
			end
			S_P_ADD: begin
				cmd.add = 1'b1;
				nxt     = S_P_PRE;
			end
			S_P_PRE: begin
				cmd.pre = 1'b1;
				nxt     = S_P_DIV;
			end
			S_P_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_done) begin
					nxt = S_P_EMT;
				end
			end
			S_P_EMT: begin
				if (st.out_free) begin
					cmd.emit_smp = 1'b1;
					if (st.last_sel || st.jnt_last) begin
						nxt = S_IDLE;
					end else begin
						cmd.jnt_inc = 1'b1;
						nxt         = S_P_RDN;
					end
				end
			end
			S_RES: begin
				if (st.out_free) begin
					cmd.emit_res = 1'b1;
					nxt          = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
		cmd.first    = first_q;
		cmd.res_code = code_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			active_q <= 1'b0;
			first_q  <= 1'b0;
			code_q   <= RS_IDLE;
		end else begin
			state_q  <= nxt;
			active_q <= act_d;
			first_q  <= first_d;
			code_q   <= code_d;
		end
	end

`ifndef SYNTHESIS
	// a sample flagged last ends the tick
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_smp && st.last_sel) |=> (state_q == S_IDLE))
		else $error("tick continued after final sample");
	// inputs are never taken during the clearing pass
	a_clr_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !cmd.accept)
		else $error("item accepted during clearing pass");
	// a finished or cancelled result leaves the motion inactive
	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_res && (code_q == RS_FINISHED || code_q == RS_CANCELED)) |-> !active_q)
		else $error("motion still active after end result");
`endif

endmodule

FILE: sv/kji_dp.sv
// Datapath: keyframe storage, keyframe search, joint checks, interpolation
// multiply and bit-serial rounding divider, output word register.
// Depends on kji_pkg and kji_ram.
module kji_dp
	import kji_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  kji_cmd_t         cmd,
	output kji_stat_t        st,
	input  logic [2:0]       op,
	input  in_item_t         item,
	input  logic             cfg_valid,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [2:0]       out_status,
	output out_item_t        out_item,
	output logic             out_last
);

	// keyframe times and start frame
	logic [TIME_W-1:0]       ft_q [MAX_KF];
	logic signed [POS_W-1:0] start_pos_q [NUM_JNT];
	logic [CNT_W-1:0]        kc_q;
	logic [CNT_W-1:0]        cnt;

	// clearing pass and entry RAM
	logic [RAM_AW-1:0] clr_cnt_q;
	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr, ram_raddr;
	kf_entry_t         wr_ent, rd_ent;
	logic              is_load;

	// search state
	logic [KF_W-1:0]   scan_i_q;
	logic              prev_start_q, next_found_q;
	logic [KF_W-1:0]   prev_i_q, next_i_q;
	logic [TIME_W-1:0] t_q, prev_t_q, next_t_q, cur_t;
	logic [DUR_W-1:0]  tf_q, tt_q, dur_q;

	// joint pass
	logic [JN_W-1:0]    j_q;
	logic [NUM_JNT-1:0] mask_q, mask_sh;
	kf_entry_t          nxt_q;
	logic               sel_now, miss_now, miss_q;
	logic [JN_W-1:0]    miss_j_q;

	// arithmetic
	logic signed [POS_W-1:0]  pp;
	logic signed [PROD_W-1:0] prod_a_q, prod_b_q;
	logic signed [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]         mag, dvd;
	logic                     neg_q;
	logic [DUR_W-1:0]         rem_q;
	logic [QUO_W-1:0]         lo_q;
	logic [DCNT_W-1:0]        dcnt_q;
	logic [DUR_W:0]           trial;
	logic                     ge;
	logic [QUO_W-1:0]         qs;

	logic out_load;

	assign cnt     = (kc_q > CNT_W'(MAX_KF)) ? CNT_W'(MAX_KF) : kc_q;
	assign is_load = cmd.accept && (op == OP_LOAD);
	assign cur_t   = ft_q[scan_i_q];

	always_comb begin
		wr_ent.pos_ok = item.has_position;
		wr_ent.pos    = item.position;
		wr_ent.stf_ok = item.has_stiffness;
		wr_ent.stf    = (item.stiffness > STF_MAX) ? STF_MAX : item.stiffness;
		if (cmd.clr) begin
			wr_ent = '0;
		end
	end

	assign ram_we    = cmd.clr || is_load;
	assign ram_waddr = cmd.clr ? clr_cnt_q
		: {item.frame_index[KF_W-1:0], item.joint_index[JN_W-1:0]};
	assign ram_raddr = {cmd.rd_prev ? prev_i_q : next_i_q, j_q};

	kji_ram #(
		.WIDTH($bits(kf_entry_t)),
		.DEPTH(RAM_DEPTH)
	) u_ent_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_ent),
		.raddr(ram_raddr),
		.rdata(rd_ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q      <= '0;
			clr_cnt_q <= '0;
			for (int k = 0; k < NUM_JNT; k++) begin
				start_pos_q[k] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				kc_q <= cfg_data;
			end
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.accept && op == OP_START) begin
				start_pos_q[item.joint_index[JN_W-1:0]] <= item.position;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_load) begin
			ft_q[item.frame_index[KF_W-1:0]] <= item.elapsed_ms;
		end
	end

	// keyframe search, one slot a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_i_q     <= '0;
			prev_start_q <= 1'b1;
			next_found_q <= 1'b0;
		end else if (cmd.scan_clr) begin
			scan_i_q     <= '0;
			prev_start_q <= 1'b1;
			next_found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_i_q <= scan_i_q + 1'b1;
			if (t_q >= cur_t) begin
				prev_start_q <= 1'b0;
			end else begin
				next_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			t_q <= item.elapsed_ms;
		end
		if (cmd.scan_clr) begin
			prev_t_q <= '0;
			prev_i_q <= '0;
			next_i_q <= '0;
		end else if (cmd.scan_step) begin
			if (t_q >= cur_t) begin
				prev_i_q <= scan_i_q;
				prev_t_q <= cur_t;
			end else if (!next_found_q) begin
				next_i_q <= scan_i_q;
				next_t_q <= cur_t;
			end
		end
		// settle long before the first multiply
		tf_q  <= DUR_W'(t_q) - DUR_W'(prev_t_q);
		tt_q  <= DUR_W'(next_t_q) - DUR_W'(t_q);
		dur_q <= tf_q + tt_q;
	end

	// joint passes
	assign sel_now  = cmd.first ? nxt_q.pos_ok : mask_q[j_q];
	assign miss_now = sel_now && (!nxt_q.pos_ok || !nxt_q.stf_ok
		|| (!prev_start_q && !rd_ent.pos_ok));
	assign mask_sh  = mask_q >> j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			j_q    <= '0;
			miss_q <= 1'b0;
		end else begin
			if (cmd.mask_clr) begin
				mask_q <= '0;
			end else if (cmd.chk_eval && cmd.first) begin
				mask_q[j_q] <= nxt_q.pos_ok;
			end
			if (cmd.jnt_clr) begin
				j_q <= '0;
			end else if (cmd.jnt_inc) begin
				j_q <= j_q + 1'b1;
			end
			if (cmd.scan_clr) begin
				miss_q <= 1'b0;
			end else if (cmd.chk_eval && miss_now) begin
				miss_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_nxt) begin
			nxt_q <= rd_ent;
		end
		if (cmd.chk_eval && miss_now && !miss_q) begin
			miss_j_q <= j_q;
		end
	end

	// interpolation and rounding divide
	assign pp    = prev_start_q ? start_pos_q[j_q] : rd_ent.pos;
	assign mag   = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign dvd   = mag + NUM_W'(dur_q >> 1);
	assign trial = {rem_q, lo_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, dur_q};
	assign qs    = neg_q ? QUO_W'(-lo_q) : lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.pre) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_a_q <= PROD_W'(pp) * PROD_W'($signed({1'b0, tt_q[TIME_W-1:0]}));
			prod_b_q <= PROD_W'(nxt_q.pos) * PROD_W'($signed({1'b0, tf_q[TIME_W-1:0]}));
		end
		if (cmd.add) begin
			num_q <= NUM_W'(prod_a_q) + NUM_W'(prod_b_q);
		end
		if (cmd.pre) begin
			neg_q <= num_q[NUM_W-1];
			rem_q <= dvd[NUM_W-1:QUO_W];
			lo_q  <= dvd[QUO_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? DUR_W'(trial - {1'b0, dur_q}) : trial[DUR_W-1:0];
			lo_q  <= {lo_q[QUO_W-2:0], ge};
		end
	end

	// output word register
	assign out_load = cmd.emit_smp || cmd.emit_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_smp) begin
			out_status               <= RS_SAMPLE;
			out_item.joint_number    <= 5'(j_q);
			out_item.joint_position  <= qs[POS_W-1:0];
			out_item.joint_stiffness <= nxt_q.stf;
			out_last                 <= (mask_sh[NUM_JNT-1:1] == '0);
		end else if (cmd.emit_res) begin
			out_status               <= cmd.res_code;
			out_item.joint_number    <= (cmd.res_code == RS_MISSING) ? 5'(miss_j_q) : 5'd0;
			out_item.joint_position  <= '0;
			out_item.joint_stiffness <= '0;
			out_last                 <= 1'b1;
		end
	end

	always_comb begin
		st.clr_done  = (clr_cnt_q == RAM_AW'(RAM_DEPTH - 1));
		st.cnt_zero  = (cnt == '0);
		st.scan_last = (CNT_W'(scan_i_q) == cnt - 1'b1);
		st.cur_ge    = (t_q >= cur_t);
		st.jnt_last  = (j_q == JN_W'(NUM_JNT - 1));
		st.jnt_sel   = mask_q[j_q];
		st.missing   = miss_q || (cmd.chk_eval && miss_now);
		st.div_done  = (dcnt_q == DCNT_W'(QUO_W - 1));
		st.out_free  = !out_valid || out_ready;
		st.last_sel  = (mask_sh[NUM_JNT-1:1] == '0);
	end

`ifndef SYNTHESIS
	// never overwrite a word that is still waiting
	a_out_safe: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid || out_ready))
		else $error("output word overwritten");
	// partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < dur_q))
		else $error("divider remainder out of range");
	// samples only for selected joints
	a_smp_sel: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_smp |-> mask_q[j_q])
		else $error("sample for unselected joint");
`endif

endmodule

FILE: sv/keyframe_joint_interpolator_top.sv
// Keyframe joint interpolator: takes one input word at a time. Loads,
// start-position writes and begin return straight to idle; a cancel or
// idle tick first passes through the result state. A tick scans the valid
// keyframes one per cycle, checks all 32 joints through the single read
// port of the entry RAM (read next, read previous, evaluate), then handles
// each selected joint (two RAM reads, multiply, add, divider preset,
// bit-serial rounding divide, output) and skips each unselected joint below
// the highest selected one. After reset the entry RAM is cleared one entry
// a cycle, and no input word is taken until it is done. Results sit in an
// output register, so a stalled result only holds the block once the next
// is ready.
// Depends on kji_pkg, kji_ctrl, kji_dp, kji_ram.
module keyframe_joint_interpolator_top
	import kji_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// frame_index, joint_index, elapsed_ms, position, stiffness,
	// has_position, has_stiffness
	input  logic [63:0] s_axis_tdata,
	// op
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// joint_number, joint_position, joint_stiffness
	output logic [39:0] m_axis_tdata,
	// status
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);

	kji_cmd_t  cmd;
	kji_stat_t st;
	in_item_t  item;
	out_item_t oitem;

	assign item      = s_axis_tdata[$bits(in_item_t)-1:0];
	assign cfg_ready = 1'b1;
	assign m_axis_tdata = {{(40 - $bits(out_item_t)){1'b0}}, oitem};

	kji_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.op      (s_axis_tuser),
		.in_ready(s_axis_tready),
		.st      (st),
		.cmd     (cmd)
	);

	kji_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.op        (s_axis_tuser),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_status(m_axis_tuser),
		.out_item  (oitem),
		.out_last  (m_axis_tlast)
	);

endmodule
